/* src/mgef_pkg.sv */
// Shared types, widths, codes and kernel arithmetic for the masked gradient edge filter.
// Used by the core and by its port checker; depends on nothing else.
package mgef_pkg;

  localparam int PIX_W      = 8;
  localparam int KERNEL_W   = 2;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIFF_W     = PIX_W + 2;
  localparam int GRAD_W     = 14;

  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;
  localparam logic [FH_W-1:0] MIN_HEIGHT = 13'd3;
  localparam logic [FW_W-1:0] FW_RESET   = 11'd640;
  localparam logic [FH_W-1:0] FH_RESET   = 13'd480;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TYPE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // Kernel codes; the unused code falls back to Sobel
  localparam logic [KERNEL_W-1:0] KERN_SOBEL   = 2'd0;
  localparam logic [KERNEL_W-1:0] KERN_PREWITT = 2'd1;
  localparam logic [KERNEL_W-1:0] KERN_SCHARR  = 2'd2;

  // One stored tap: mask above the grey level
  typedef struct packed {
    logic             mask;
    logic [PIX_W-1:0] pix;
  } tap_t;

  // Weighted sum of three row (or column) differences: outer rows share one
  // weight, the middle row has the other.
  function automatic logic signed [GRAD_W-1:0] kernel_sum(
    input logic [KERNEL_W-1:0]      kern,
    input logic signed [DIFF_W-1:0] d0,
    input logic signed [DIFF_W-1:0] d1,
    input logic signed [DIFF_W-1:0] d2
  );
    logic signed [GRAD_W-1:0] outer;
    logic signed [GRAD_W-1:0] mid;
    logic signed [GRAD_W-1:0] sum;
    outer = GRAD_W'(d0) + GRAD_W'(d2);
    mid   = GRAD_W'(d1);
    unique case (kern)
      KERN_PREWITT: sum = outer + mid;
      KERN_SCHARR:  sum = (outer <<< 1) + outer + (mid <<< 3) + (mid <<< 1);
      default:      sum = outer + (mid <<< 1);
    endcase
    return sum;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_byte(input logic signed [GRAD_W-1:0] v);
    logic [PIX_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > GRAD_W'(255)) begin
      r = '1;
    end else begin
      r = v[PIX_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/masked_gradient_edge_filter_core.sv */
// Masked 3x3 gradient edge filter: line stores, window registers and result stage.
// Depends on mgef_pkg.
//
//  channel | group           | fields (low bit up)
//  --------+-----------------+---------------------------------------------
//  input   | in_t*           | tdata: pixel[7:0]; tuser: mask_bit
//  output  | out_t*          | tdata: edge_value[7:0]; tuser: window_valid;
//          |                 | tlast: last_of_frame
//  config  | cfg_we/idx/data | 0 kernel_type, 1 frame_width, 2 frame_height
//
// One word per clock sustained while the output is not stalled. After a word is accepted,
// the line store read is registered with the word, then the window shift and gradient
// sum load the result register. Border words update state but give no result.
// Reset clears config, counters, window and valids; the line stores need no clearing.
// A stalled output holds the result stage and backs the pipe up to in_tready.
module masked_gradient_edge_filter_core #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [mgef_pkg::PIX_W-1:0]           in_tdata,   // pixel
  input  logic                                 in_tuser,   // mask_bit
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [mgef_pkg::PIX_W-1:0]           out_tdata,  // edge_value
  output logic                                 out_tuser,  // window_valid
  output logic                                 out_tlast,
  input  logic                                 cfg_we,
  input  logic [mgef_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mgef_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int CWP = CW + 1;

  // configuration
  logic [mgef_pkg::KERNEL_W-1:0] kernel_type_r;
  logic [mgef_pkg::FW_W-1:0]     frame_width_r;
  logic [mgef_pkg::FH_W-1:0]     frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_type_r  <= mgef_pkg::KERN_SOBEL;
      frame_width_r  <= mgef_pkg::FW_RESET;
      frame_height_r <= mgef_pkg::FH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mgef_pkg::CFG_KERNEL_TYPE:  kernel_type_r  <= cfg_wdata[mgef_pkg::KERNEL_W-1:0];
        mgef_pkg::CFG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata[mgef_pkg::FW_W-1:0];
        mgef_pkg::CFG_FRAME_HEIGHT: frame_height_r <= cfg_wdata[mgef_pkg::FH_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  logic [CWP-1:0]               w_eff;
  logic [mgef_pkg::FH_W-1:0]    h_eff;

  always_comb begin
    if (frame_width_r < mgef_pkg::FW_W'(3)) begin
      w_eff = CWP'(3);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w_eff = CWP'(MAX_WIDTH);
    end else begin
      w_eff = CWP'(frame_width_r);
    end
    if (frame_height_r < mgef_pkg::MIN_HEIGHT) begin
      h_eff = mgef_pkg::MIN_HEIGHT;
    end else if (frame_height_r > mgef_pkg::MAX_HEIGHT) begin
      h_eff = mgef_pkg::MAX_HEIGHT;
    end else begin
      h_eff = frame_height_r;
    end
  end

  // handshake and pipe control
  logic in_acc;
  logic b_adv;
  logic b_valid_r, b_valid_nxt;
  logic out_valid_r, out_valid_nxt;

  assign b_adv     = b_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !b_valid_r || b_adv;
  assign in_acc    = in_tvalid && in_tready;

  // position of the incoming word
  logic [CW-1:0]              col_r, col_nxt;
  logic [mgef_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [CWP-1:0]             col_inc;
  logic [mgef_pkg::FH_W-1:0]  row_inc;
  logic                       row_end;
  logic                       frame_end;
  logic                       produce;
  logic                       last;

  assign col_inc   = {1'b0, col_r} + CWP'(1);
  assign row_inc   = {1'b0, row_r} + mgef_pkg::FH_W'(1);
  assign row_end   = col_inc >= w_eff;
  assign frame_end = row_inc >= h_eff;
  assign produce   = (row_r >= mgef_pkg::ROW_W'(2)) && (col_r >= CW'(2));
  assign last      = row_end && frame_end;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_inc[mgef_pkg::ROW_W-1:0];
      end else begin
        col_nxt = col_inc[CW-1:0];
      end
    end
  end

  // line stores: line0 holds the row above, line1 the row above that
  mgef_pkg::tap_t line0_mem [MAX_WIDTH];
  mgef_pkg::tap_t line1_mem [MAX_WIDTH];
  mgef_pkg::tap_t mid_rd_r;
  mgef_pkg::tap_t top_rd_r;
  mgef_pkg::tap_t b_cur_r;
  logic [CW-1:0]  b_col_r;
  logic           b_prod_r;
  logic           b_last_r;

  // a column repeats no sooner than three words later, so the write from the
  // result side never collides with the read of the same column
  always_ff @(posedge clk) begin
    if (b_adv) begin
      line0_mem[b_col_r] <= b_cur_r;
    end
    if (in_acc) begin
      mid_rd_r <= line0_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      line1_mem[b_col_r] <= mid_rd_r;
    end
    if (in_acc) begin
      top_rd_r <= line1_mem[col_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_cur_r  <= '{mask: in_tuser, pix: in_tdata};
      b_col_r  <= col_r;
      b_prod_r <= produce;
      b_last_r <= last;
    end
  end

  assign b_valid_nxt = in_acc ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);

  // window: [row][column], row 0 on top, column 0 oldest
  mgef_pkg::tap_t win_r   [3][3];
  mgef_pkg::tap_t win_nxt [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = top_rd_r;
    win_nxt[1][2] = mid_rd_r;
    win_nxt[2][2] = b_cur_r;
  end

  // gradients on the shifted window
  logic signed [mgef_pkg::DIFF_W-1:0] dx [3];
  logic signed [mgef_pkg::DIFF_W-1:0] dy [3];
  logic signed [mgef_pkg::GRAD_W-1:0] sx, sy;
  logic                               all_mask;
  logic [mgef_pkg::PIX_W-1:0]         gx, gy;
  logic [mgef_pkg::PIX_W:0]           gsum;
  logic [mgef_pkg::PIX_W-1:0]         avg;

  always_comb begin
    all_mask = 1'b1;
    for (int i = 0; i < 3; i++) begin
      dx[i] = mgef_pkg::DIFF_W'(win_nxt[i][2].pix) - mgef_pkg::DIFF_W'(win_nxt[i][0].pix);
      dy[i] = mgef_pkg::DIFF_W'(win_nxt[2][i].pix) - mgef_pkg::DIFF_W'(win_nxt[0][i].pix);
      for (int j = 0; j < 3; j++) begin
        all_mask = all_mask & win_nxt[i][j].mask;
      end
    end
    sx   = mgef_pkg::kernel_sum(kernel_type_r, dx[0], dx[1], dx[2]);
    sy   = mgef_pkg::kernel_sum(kernel_type_r, dy[0], dy[1], dy[2]);
    gx   = all_mask ? mgef_pkg::clamp_byte(sx) : '0;
    gy   = all_mask ? mgef_pkg::clamp_byte(sy) : '0;
    gsum = {1'b0, gx} + {1'b0, gy};
    // halve, round half to even
    avg  = gsum[mgef_pkg::PIX_W:1] + mgef_pkg::PIX_W'(gsum[0] & gsum[1]);
  end

  assign out_valid_nxt = (b_adv && b_prod_r) ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  logic [mgef_pkg::PIX_W-1:0] out_data_r;
  logic                       out_user_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (b_adv && b_prod_r) begin
      out_data_r <= avg;
      out_user_r <= all_mask;
      out_last_r <= b_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      b_valid_r   <= b_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (b_adv) begin
        win_r <= win_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

/* src/mgef_checker.sv */
// Port-level checks for the masked gradient edge filter core, and the bind that attaches them.
// Depends on mgef_pkg and masked_gradient_edge_filter_core.
module mgef_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mgef_pkg::PIX_W-1:0]      out_tdata,
  input logic                            out_tuser,
  input logic                            out_tlast
);

  // reset empties the result stage
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  // a masked window always reports zero
  a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("masked window gave a nonzero edge value");

  // a fresh result needs an earlier accepted input word
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(in_tvalid && in_tready, 2))
    else $error("result word without an accepted input word");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("stalled result word changed");

endmodule

bind masked_gradient_edge_filter_core mgef_checker u_mgef_checker (.*);
